/* rtl/m3ema_pkg.sv */
// shared widths and constants for the median-of-three smoothing filter
package m3ema_pkg;

    localparam int TEMP_W    = 11;  // signed tenths of a degree
    localparam int FACTOR_W  = 7;   // blend factor in hundredths
    localparam int POS_W     = 2;   // store write position
    localparam int NUM_W     = 18;  // signed weighted sum, |sum| <= 102400
    localparam int MAG_W     = 17;  // magnitude of the sum plus the rounding half
    localparam int PROD_W    = 30;  // magnitude times reciprocal

    localparam logic [FACTOR_W-1:0] FACTOR_SCALE = 7'd100;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 7'd45;
    localparam logic [MAG_W-1:0]    ROUND_HALF   = 17'd50;
    localparam logic [MAG_W-1:0]    DIVISOR      = 17'd100;

    // floor(2^19 / 100); the estimate is the true quotient or one below it
    localparam logic [PROD_W-1:0]   DIV_RECIP    = 30'd5242;
    localparam int                  DIV_SHIFT    = 19;

    localparam logic [POS_W-1:0]    POS_LAST     = 2'd2;

    typedef logic signed [TEMP_W-1:0] temp_t;

endpackage

/* rtl/median3_ema_smoother.sv */
// median-of-three filter with exponential moving average blend, top level
//
// Usage:
//   sample channel: sample_valid/sample_stall carry a word of sample and
//   previous_value; a word is taken at a rising edge with valid high and
//   stall low.
//   result channel: result_valid/result_stall carry filtered and updated,
//   one result word for every sample word, in order.
//   cfg channel: cfg_valid/cfg_ready write blend_factor (cfg_ready is always
//   high); values above 100 act as 100. Write it only while the block is idle.
// A taken word passes stages 1 to 4 and then the output register before its result shows.
// Throughput: one word per cycle while results are not stalled, set by a five-register
//   pipeline in which every stage can load while it is empty or while the one after it moves.
// The first sample after reset fills the three-entry store and gives an
//   update; after that every third sample gives one.
// Reset: pipeline empty, factor 45, store not primed.
// Stall: a held result keeps its word; earlier stages keep filling bubbles
//   and sample_stall rises only once every stage holds a word.
module median3_ema_smoother
    import m3ema_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [FACTOR_W-1:0]        cfg_data,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [TEMP_W-1:0]   sample,
    input  logic signed [TEMP_W-1:0]   previous_value,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [TEMP_W-1:0]   filtered,
    output logic                       updated
);

    // control
    logic [FACTOR_W-1:0] factor_reg;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                primed_reg;
    logic                s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, out_vld_reg;
    logic                ld1, ld2, ld3, ld4, ld5;
    logic                accept;
    logic                full_next;

    // sample store, no reset: read only after priming writes every entry
    temp_t               store_reg [3];
    temp_t               store_next [3];

    // stage 1: store snapshot
    temp_t               s1_a_reg [3];
    temp_t               s1_prev_reg;
    logic                s1_full_reg;

    // stage 2: weighted sum
    logic signed [NUM_W-1:0] s2_num_reg;
    temp_t               s2_prev_reg;
    logic                s2_full_reg;

    // stage 3: magnitude plus half
    logic [MAG_W-1:0]    s3_x_reg;
    logic                s3_neg_reg;
    temp_t               s3_prev_reg;
    logic                s3_full_reg;

    // stage 4: quotient estimate
    logic [MAG_W-1:0]    s4_x_reg;
    logic [TEMP_W-1:0]   s4_q0_reg;
    logic                s4_neg_reg;
    temp_t               s4_prev_reg;
    logic                s4_full_reg;

    // output register
    temp_t               out_val_reg;
    logic                out_upd_reg;

    // combinational
    temp_t               med;
    temp_t               lo_ab, hi_ab, lo_hc;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]    mag;
    logic [PROD_W-1:0]   prod;
    logic [MAG_W-1:0]    rem;
    logic [TEMP_W-1:0]   quot;
    temp_t               blend_val;

    assign cfg_ready = 1'b1;

    assign ld5 = !out_vld_reg || !result_stall;
    assign ld4 = !s4_vld_reg  || ld5;
    assign ld3 = !s3_vld_reg  || ld4;
    assign ld2 = !s2_vld_reg  || ld3;
    assign ld1 = !s1_vld_reg  || ld2;

    assign sample_stall = !ld1;
    assign accept       = sample_valid && ld1;

    // store write and fill position
    always_comb
    begin
        full_next = 1'b0;
        pos_next  = pos_reg;
        for (int k = 0; k < 3; k++)
        begin
            store_next[k] = store_reg[k];
            if (!primed_reg || pos_reg == POS_W'(k))
            begin
                store_next[k] = sample;
            end
        end
        if (!primed_reg)
        begin
            pos_next  = '0;
            full_next = 1'b1;
        end
        else if (pos_reg == POS_LAST)
        begin
            pos_next  = '0;
            full_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // median of three and weighted sum
    always_comb
    begin
        lo_ab = (s1_a_reg[0] < s1_a_reg[1]) ? s1_a_reg[0] : s1_a_reg[1];
        hi_ab = (s1_a_reg[0] > s1_a_reg[1]) ? s1_a_reg[0] : s1_a_reg[1];
        lo_hc = (hi_ab < s1_a_reg[2]) ? hi_ab : s1_a_reg[2];
        med   = (lo_ab > lo_hc) ? lo_ab : lo_hc;
        num   = NUM_W'($signed({1'b0, factor_reg})) * NUM_W'(med)
              + NUM_W'($signed({1'b0, FACTOR_SCALE - factor_reg})) * NUM_W'(s1_prev_reg);
    end

    // magnitude, reciprocal estimate, one-step correction
    always_comb
    begin
        mag       = s2_num_reg[NUM_W-1] ? NUM_W'(-s2_num_reg) : NUM_W'(s2_num_reg);
        prod      = PROD_W'(s3_x_reg) * DIV_RECIP;
        rem       = s4_x_reg - MAG_W'(MAG_W'(s4_q0_reg) * DIVISOR);
        quot      = (rem >= DIVISOR) ? s4_q0_reg + TEMP_W'(1) : s4_q0_reg;
        blend_val = s4_neg_reg ? temp_t'(-quot) : temp_t'(quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg  <= FACTOR_RESET;
            pos_reg     <= '0;
            primed_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                factor_reg <= (cfg_data > FACTOR_SCALE) ? FACTOR_SCALE : cfg_data;
            end
            if (accept)
            begin
                pos_reg    <= pos_next;
                primed_reg <= 1'b1;
            end
            if (ld1) s1_vld_reg  <= sample_valid;
            if (ld2) s2_vld_reg  <= s1_vld_reg;
            if (ld3) s3_vld_reg  <= s2_vld_reg;
            if (ld4) s4_vld_reg  <= s3_vld_reg;
            if (ld5) out_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                store_reg[k] <= store_next[k];
                s1_a_reg[k]  <= store_next[k];
            end
            s1_prev_reg <= previous_value;
            s1_full_reg <= full_next;
        end
        if (ld2 && s1_vld_reg)
        begin
            s2_num_reg  <= num;
            s2_prev_reg <= s1_prev_reg;
            s2_full_reg <= s1_full_reg;
        end
        if (ld3 && s2_vld_reg)
        begin
            s3_x_reg    <= MAG_W'(mag) + ROUND_HALF;
            s3_neg_reg  <= s2_num_reg[NUM_W-1];
            s3_prev_reg <= s2_prev_reg;
            s3_full_reg <= s2_full_reg;
        end
        if (ld4 && s3_vld_reg)
        begin
            s4_x_reg    <= s3_x_reg;
            s4_q0_reg   <= prod[DIV_SHIFT +: TEMP_W];
            s4_neg_reg  <= s3_neg_reg;
            s4_prev_reg <= s3_prev_reg;
            s4_full_reg <= s3_full_reg;
        end
        if (ld5 && s4_vld_reg)
        begin
            out_val_reg <= s4_full_reg ? blend_val : s4_prev_reg;
            out_upd_reg <= s4_full_reg;
        end
    end

    assign result_valid = out_vld_reg;
    assign filtered     = out_val_reg;
    assign updated      = out_upd_reg;

    // fill position only walks the three entries
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 2'd3)
        else $error("fill position out of range");

    // the first word after reset always gives an update
    a_prime_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !primed_reg) |=> (s1_vld_reg && s1_full_reg))
        else $error("priming word did not mark the store full");

    // the reciprocal estimate is never more than one below the quotient
    a_div_corr: assert property (@(posedge clk) disable iff (!rst_n)
        s4_vld_reg |-> (rem < (DIVISOR + DIVISOR)))
        else $error("quotient estimate off by more than one");

    // stored factor is always saturated
    a_factor_sat: assert property (@(posedge clk) disable iff (!rst_n)
        factor_reg <= FACTOR_SCALE)
        else $error("blend factor above scale");

endmodule
